[hw/rtl/uvst_pkg.sv]
// ----------------------------------------------------------------------------
// uvst_pkg
// Shared types, register codes and the quarter-wave sine generator for the
// UV sphere tile block.
// ----------------------------------------------------------------------------
package uvst_pkg;

  localparam int DEF_MAX_DIVISIONS    = 256;
  localparam int DEF_SINE_TABLE_DEPTH = 1024;

  localparam int CNT_W = 9;    // stack / slice count
  localparam int IDX_W = 8;    // stack / slice index
  localparam int RAD_W = 16;   // radius, Q8.8
  localparam int QW    = 20;   // quotient of k * 2^FRAC / count
  localparam int FRAC  = 17;
  localparam int MAG_W = 15;   // sine magnitude, Q1.14 up to 16384
  localparam int POS_W = 17;
  localparam int NRM_W = 16;
  localparam int TEX_W = 17;
  localparam int VERTS = 6;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_STACKS = 2'd1;
  localparam logic [1:0] REG_SLICES = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
  localparam logic [CNT_W-1:0] STACKS_RST = 9'd16;
  localparam logic [CNT_W-1:0] SLICES_RST = 9'd16;

  // One tile after division: quotients for both latitudes and longitudes
  typedef struct packed {
    logic          bad;
    logic [QW-1:0] q_lat0;
    logic [QW-1:0] q_lat1;
    logic [QW-1:0] q_lon0;
    logic [QW-1:0] q_lon1;
  } tile_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] norm_x;
    logic signed [NRM_W-1:0] norm_y;
    logic signed [NRM_W-1:0] norm_z;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic                    last;
    logic                    bad;
  } vertex_t;

  // Odd polynomial through x^11, Q30 Horner, rounded to Q1.14.
  // idx is the quarter-wave position divided by four; lg is log2 of the depth.
  function automatic logic [MAG_W-1:0] sine_mag(input int unsigned idx,
                                                input int unsigned lg);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = longint'(idx) << (32 - lg);
    x2 = (x * x) >> 30;
    t  = 64'd172272 - ((x2 * 64'd3864) >> 30);
    t  = 64'd5026995 - ((x2 * t) >> 30);
    t  = 64'd85569306 - ((x2 * t) >> 30);
    t  = 64'd693598668 - ((x2 * t) >> 30);
    t  = 64'd1686629713 - ((x2 * t) >> 30);
    s  = (x * t) >> 30;
    s  = (s + 64'd32768) >> 16;
    if (s > 64'd16384) s = 64'd16384;
    return MAG_W'(s);
  endfunction

endpackage

[hw/rtl/uv_sphere_tile_vertices.sv]
// ----------------------------------------------------------------------------
// uv_sphere_tile_vertices
// Expands one UV sphere tile into two triangles: six vertices with
// position, unit normal and texture coordinate.
// ----------------------------------------------------------------------------
// Throughput: one vertex per cycle while m_tready is high; set by the
//   six-vertex emitter.
// Reset: rst, synchronous; clears all control state and loads the
//   registers with radius 1.0, 16 stacks, 16 slices. No clearing pass.
// ----------------------------------------------------------------------------
module uv_sphere_tile_vertices #(
  parameter int MAX_DIVISIONS    = uvst_pkg::DEF_MAX_DIVISIONS,
  parameter int SINE_TABLE_DEPTH = uvst_pkg::DEF_SINE_TABLE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  // configuration write
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata,
  // tile in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // stack_index[7:0], slice_index[15:8]
  // vertex out
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y,
                                  // norm_z, tex_u, tex_v, zero pad
  output logic         m_tlast,   // last_vertex
  output logic         m_tuser    // bad_tile
);
  import uvst_pkg::*;

  localparam int MAX_CLIP_I = (MAX_DIVISIONS < 511) ? MAX_DIVISIONS : 511;
  localparam logic [CNT_W-1:0] MAX_CLIP = CNT_W'(MAX_CLIP_I);

  logic [RAD_W-1:0] radius;
  logic [CNT_W-1:0] stack_count;
  logic [CNT_W-1:0] slice_count;
  logic [CNT_W-1:0] stacks;
  logic [CNT_W-1:0] slices;

  // config registers; an unused index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= RADIUS_RST;
      stack_count <= STACKS_RST;
      slice_count <= SLICES_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_RADIUS: radius      <= cfg_wdata;
        REG_STACKS: stack_count <= cfg_wdata[CNT_W-1:0];
        REG_SLICES: slice_count <= cfg_wdata[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // a zero count acts as one, anything above the cap as the cap
  always_comb begin
    if (stack_count == '0)                      stacks = CNT_W'(1);
    else if (int'(stack_count) > MAX_DIVISIONS) stacks = MAX_CLIP;
    else                                        stacks = stack_count;
    if (slice_count == '0)                      slices = CNT_W'(1);
    else if (int'(slice_count) > MAX_DIVISIONS) slices = MAX_CLIP;
    else                                        slices = slice_count;
  end

  tile_t   fq_data;
  logic    fq_valid;
  logic    fq_ready;
  tile_t   qb_data;
  logic    qb_valid;
  logic    qb_ready;
  vertex_t vtx;

  // front: transfer, bad check, four-lane divider
  uvst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .stacks   (stacks),
    .slices   (slices),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  // decouples the divider from the lookup/emit side
  uvst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  // back: dual-port table reads for the four angles, then six vertices
  uvst_back #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .radius    (radius),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_vtx   (vtx)
  );

  assign m_tdata = {3'b000, vtx.tex_v, vtx.tex_u, vtx.norm_z, vtx.norm_y,
                    vtx.norm_x, vtx.pos_z, vtx.pos_y, vtx.pos_x};
  assign m_tlast = vtx.last;
  assign m_tuser = vtx.bad;

endmodule

[hw/rtl/uvst_front.sv]
// ----------------------------------------------------------------------------
// uvst_front
// Accepts a tile, flags bad indices and divides the four angle indices by
// their counts, four quotient bits per cycle on four lanes.
// ----------------------------------------------------------------------------
module uvst_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,   // stack_index, slice_index
  input  logic [uvst_pkg::CNT_W-1:0]  stacks,
  input  logic [uvst_pkg::CNT_W-1:0]  slices,
  output logic                        q_valid,
  input  logic                        q_ready,
  output uvst_pkg::tile_t             q_data
);
  import uvst_pkg::*;

  localparam int LANES = 4;
  localparam int BPS   = 4;
  localparam int STEPS = QW / BPS;

  logic             busy;
  logic             done;
  logic [2:0]       cnt;
  logic             bad;
  logic [CNT_W-1:0] rem      [LANES];
  logic [QW-1:0]    quo      [LANES];
  logic [CNT_W-1:0] rem_next [LANES];
  logic [QW-1:0]    quo_next [LANES];
  logic [CNT_W-1:0] kval     [LANES];
  logic             acc;
  logic             push;
  logic [IDX_W-1:0] stack_idx;
  logic [IDX_W-1:0] slice_idx;

  assign stack_idx = s_tdata[7:0];
  assign slice_idx = s_tdata[15:8];
  assign q_valid   = done;
  assign push      = q_valid & q_ready;
  assign s_tready  = ~busy | push;
  assign acc       = s_tvalid & s_tready;

  assign kval[0] = {1'b0, stack_idx};
  assign kval[1] = {1'b0, stack_idx} + 9'd1;
  assign kval[2] = {1'b0, slice_idx};
  assign kval[3] = {1'b0, slice_idx} + 9'd1;

  // restoring division, latitude lanes by stacks, longitude lanes by slices
  always_comb begin
    logic [CNT_W-1:0] r;
    logic [QW-1:0]    d;
    logic [CNT_W:0]   tr;
    logic [CNT_W-1:0] dv;
    for (int l = 0; l < LANES; l++) begin
      r  = rem[l];
      d  = quo[l];
      dv = (l < 2) ? stacks : slices;
      for (int b = 0; b < BPS; b++) begin
        tr = {r, d[QW-1]};
        d  = {d[QW-2:0], 1'b0};
        if (tr >= {1'b0, dv}) begin
          r    = CNT_W'(tr - {1'b0, dv});
          d[0] = 1'b1;
        end else begin
          r = tr[CNT_W-1:0];
        end
      end
      rem_next[l] = r;
      quo_next[l] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (acc) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (push) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (busy && !done) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'(STEPS - 1)) done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      bad <= (stack_idx >= stacks) | (slice_idx >= slices);
      for (int l = 0; l < LANES; l++) begin
        rem[l] <= CNT_W'(kval[l] >> (QW - FRAC));
        quo[l] <= {kval[l][QW-FRAC-1:0], {FRAC{1'b0}}};
      end
    end else if (busy && !done) begin
      for (int l = 0; l < LANES; l++) begin
        rem[l] <= rem_next[l];
        quo[l] <= quo_next[l];
      end
    end
  end

  assign q_data = '{bad: bad, q_lat0: quo[0], q_lat1: quo[1],
                    q_lon0: quo[2], q_lon1: quo[3]};

`ifndef SYNTH
  a_acc_starts: assert property (@(posedge clk) disable iff (rst)
    acc |=> busy && !done) else $error("tile not started on transfer");
  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    busy && !done |=> busy) else $error("division abandoned");
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(cnt) == 3'(STEPS - 1)) else $error("short division");
`endif

endmodule

[hw/rtl/uvst_queue.sv]
// ----------------------------------------------------------------------------
// uvst_queue
// Two-entry tile queue between the divider front and the vertex back end.
// ----------------------------------------------------------------------------
module uvst_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  uvst_pkg::tile_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output uvst_pkg::tile_t rd_data
);
  import uvst_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  tile_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    fill;
  logic           wr_en;
  logic           rd_en;

  assign wr_ready = (fill != (PW+1)'(DEPTH));
  assign rd_valid = (fill != '0);
  assign wr_en    = wr_valid & wr_ready;
  assign rd_en    = rd_valid & rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + PW'(1);
      if (rd_en) rd_ptr <= rd_ptr + PW'(1);
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + (PW+1)'(1);
        2'b01:   fill <= fill - (PW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/uvst_sine_rom.sv]
// ----------------------------------------------------------------------------
// uvst_sine_rom
// Quarter-wave sine magnitude table, two registered read ports.
// ----------------------------------------------------------------------------
module uvst_sine_rom #(
  parameter int SINE_TABLE_DEPTH = uvst_pkg::DEF_SINE_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic [$clog2(SINE_TABLE_DEPTH)-2:0] addr_a,
  input  logic [$clog2(SINE_TABLE_DEPTH)-2:0] addr_b,
  output logic [uvst_pkg::MAG_W-1:0]        data_a,
  output logic [uvst_pkg::MAG_W-1:0]        data_b
);
  import uvst_pkg::*;

  localparam int LG    = $clog2(SINE_TABLE_DEPTH);
  localparam int ROM_N = SINE_TABLE_DEPTH / 4 + 1;

  logic [MAG_W-1:0] rom [ROM_N];

  for (genvar g = 0; g < ROM_N; g++) begin : g_rom
    assign rom[g] = sine_mag(g, LG);
  end

  always_ff @(posedge clk) begin
    data_a <= rom[addr_a];
    data_b <= rom[addr_b];
  end

endmodule

[hw/rtl/uvst_back.sv]
// ----------------------------------------------------------------------------
// uvst_back
// Looks up sine and cosine of the tile's four angles, then emits six
// vertices through a two-stage multiply pipeline.
// ----------------------------------------------------------------------------
module uvst_back #(
  parameter int SINE_TABLE_DEPTH = uvst_pkg::DEF_SINE_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  uvst_pkg::tile_t            q_data,
  input  logic [uvst_pkg::RAD_W-1:0] radius,
  output logic                       out_valid,
  input  logic                       out_ready,
  output uvst_pkg::vertex_t          out_vtx
);
  import uvst_pkg::*;

  localparam int L  = $clog2(SINE_TABLE_DEPTH);
  localparam int AW = L - 1;
  localparam int KL = FRAC + 1 - L;   // latitude: k*D/(2n)
  localparam int KO = FRAC - L;       // longitude: k*D/n
  localparam logic [L-1:0] HALF = L'(SINE_TABLE_DEPTH / 2);
  localparam logic [L-1:0] QTR  = L'(SINE_TABLE_DEPTH / 4);
  localparam logic [TEX_W-1:0] ONE_TEX = TEX_W'(65536);

  // fold a full-circle position (phase units) to quarter-wave table index plus sign
  function automatic logic [AW:0] fold(input logic [L-1:0] q);
    logic [L-1:0] h;
    logic         n;
    h = q;
    n = 1'b0;
    if (h >= HALF) begin
      h = h - HALF;
      n = 1'b1;
    end
    if (h > QTR) h = HALF - h;
    return {n, AW'(h)};
  endfunction

  function automatic logic [TEX_W-1:0] tex_of(input logic [QW-1:0] q);
    logic [QW-1:0] h;
    h = (q + QW'(1)) >> 1;
    return ONE_TEX - TEX_W'(h);
  endfunction

  // ---------------- lookup ----------------
  logic             lk_busy;
  logic [1:0]       lk_cnt;
  tile_t            lk_tile;
  logic             rd_vld;
  logic [1:0]       rd_slot;
  logic             rd_nsin;
  logic             rd_ncos;
  logic [QW-1:0]    q_cur;
  logic [QW:0]      ph_sum;
  logic [L-1:0]     phase;
  logic [AW:0]      f_sin;
  logic [AW:0]      f_cos;
  logic [MAG_W-1:0] rom_a;
  logic [MAG_W-1:0] rom_b;
  logic             pop;
  logic             set_full;
  logic             set_take;
  logic [MAG_W-1:0] set_smag [4];
  logic [MAG_W-1:0] set_cmag [4];
  logic [3:0]       set_sneg;
  logic [3:0]       set_cneg;
  tile_t            set_tile;

  always_comb begin
    case (lk_cnt)
      2'd0:    q_cur = lk_tile.q_lat0;
      2'd1:    q_cur = lk_tile.q_lat1;
      2'd2:    q_cur = lk_tile.q_lon0;
      default: q_cur = lk_tile.q_lon1;
    endcase
    if (!lk_cnt[1]) begin
      ph_sum = {1'b0, q_cur} + ((QW+1)'(1) << (KL - 1));
      phase  = L'(ph_sum >> KL);
    end else begin
      ph_sum = {1'b0, q_cur} + ((QW+1)'(1) << (KO - 1));
      phase  = L'(ph_sum >> KO);
    end
    f_sin = fold(phase);
    f_cos = fold(phase + QTR);
  end

  uvst_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom (
    .clk    (clk),
    .addr_a (f_sin[AW-1:0]),
    .addr_b (f_cos[AW-1:0]),
    .data_a (rom_a),
    .data_b (rom_b)
  );

  assign pop     = q_valid & ~lk_busy & ~rd_vld & (~set_full | set_take);
  assign q_ready = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      lk_busy  <= 1'b0;
      lk_cnt   <= '0;
      rd_vld   <= 1'b0;
      set_full <= 1'b0;
    end else begin
      if (pop) begin
        lk_busy <= 1'b1;
        lk_cnt  <= '0;
      end else if (lk_busy) begin
        lk_cnt <= lk_cnt + 2'd1;
        if (lk_cnt == 2'd3) lk_busy <= 1'b0;
      end
      rd_vld   <= lk_busy;
      set_full <= (set_full & ~set_take) | (rd_vld & (rd_slot == 2'd3));
    end
  end

  always_ff @(posedge clk) begin
    if (pop) lk_tile <= q_data;
    rd_slot <= lk_cnt;
    rd_nsin <= f_sin[AW];
    rd_ncos <= f_cos[AW];
    if (rd_vld) begin
      set_smag[rd_slot] <= rom_a;
      set_cmag[rd_slot] <= rom_b;
      set_sneg[rd_slot] <= rd_nsin & (rom_a != '0);
      set_cneg[rd_slot] <= rd_ncos & (rom_b != '0);
      if (rd_slot == 2'd3) set_tile <= lk_tile;
    end
  end

  // ---------------- emitter ----------------
  logic             em_busy;
  logic [2:0]       em_k;
  logic [MAG_W-1:0] em_smag [4];
  logic [MAG_W-1:0] em_cmag [4];
  logic [3:0]       em_sneg;
  logic [3:0]       em_cneg;
  tile_t            em_tile;
  logic             adv;
  logic             em_free;
  logic             lat_sel;
  logic             lon_sel;
  logic [1:0]       li;
  logic [1:0]       oi;

  // stage 1
  logic                 v1;
  logic [2*MAG_W-1:0]   px1;
  logic [2*MAG_W-1:0]   pz1;
  logic [MAG_W-1:0]     cl1;
  logic                 ncl1;
  logic                 nx1;
  logic                 nz1;
  logic [TEX_W-1:0]     tu1;
  logic [TEX_W-1:0]     tv1;
  logic                 last1;
  logic                 bad1;

  // stage 2 arithmetic
  logic [RAD_W+2*MAG_W:0] xr;
  logic [RAD_W+2*MAG_W:0] zr;
  logic [RAD_W+MAG_W:0]   yr;
  logic [2*MAG_W:0]       xn;
  logic [2*MAG_W:0]       zn;
  logic [POS_W-1:0]       xm;
  logic [POS_W-1:0]       ym;
  logic [POS_W-1:0]       zm;
  logic [NRM_W-1:0]       xnm;
  logic [NRM_W-1:0]       znm;
  logic                   nx;
  logic                   nz;
  vertex_t                vtx_next;

  assign adv      = ~out_valid | out_ready;
  assign em_free  = ~em_busy | (adv & (em_k == 3'(VERTS - 1)));
  assign set_take = set_full & em_free;

  // corner order c1,c2,c3,c3,c4,c1
  assign lat_sel = (em_k == 3'd1) | (em_k == 3'd2) | (em_k == 3'd3);
  assign lon_sel = (em_k == 3'd0) | (em_k == 3'd1) | (em_k == 3'd5);
  assign li      = {1'b0, lat_sel};
  assign oi      = {1'b1, lon_sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      em_busy   <= 1'b0;
      em_k      <= '0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (set_take) begin
        em_busy <= 1'b1;
        em_k    <= '0;
      end else if (em_busy && adv) begin
        em_k <= em_k + 3'd1;
        if (em_k == 3'(VERTS - 1)) em_busy <= 1'b0;
      end
      if (adv) begin
        v1        <= em_busy;
        out_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (set_take) begin
      em_smag <= set_smag;
      em_cmag <= set_cmag;
      em_sneg <= set_sneg;
      em_cneg <= set_cneg;
      em_tile <= set_tile;
    end
    if (adv) begin
      px1   <= em_smag[li] * em_cmag[oi];
      pz1   <= em_smag[li] * em_smag[oi];
      cl1   <= em_cmag[li];
      ncl1  <= em_cneg[li];
      nx1   <= em_sneg[li] ^ em_cneg[oi];
      nz1   <= em_sneg[li] ^ em_sneg[oi];
      tu1   <= tex_of(lon_sel ? em_tile.q_lon1 : em_tile.q_lon0);
      tv1   <= tex_of(lat_sel ? em_tile.q_lat1 : em_tile.q_lat0);
      last1 <= (em_k == 3'(VERTS - 1));
      bad1  <= em_tile.bad;
      out_vtx <= vtx_next;
    end
  end

  always_comb begin
    xr  = (RAD_W+2*MAG_W+1)'(radius * px1) + (RAD_W+2*MAG_W+1)'(1 << 27);
    zr  = (RAD_W+2*MAG_W+1)'(radius * pz1) + (RAD_W+2*MAG_W+1)'(1 << 27);
    yr  = (RAD_W+MAG_W+1)'(radius * cl1) + (RAD_W+MAG_W+1)'(1 << 13);
    xn  = {1'b0, px1} + (2*MAG_W+1)'(1 << 13);
    zn  = {1'b0, pz1} + (2*MAG_W+1)'(1 << 13);
    xm  = POS_W'(xr >> 28);
    zm  = POS_W'(zr >> 28);
    ym  = POS_W'(yr >> 14);
    xnm = NRM_W'(xn >> 14);
    znm = NRM_W'(zn >> 14);
    nx  = nx1 & (px1 != '0);
    nz  = nz1 & (pz1 != '0);
    vtx_next.pos_x  = nx   ? -xm  : xm;
    vtx_next.pos_y  = ncl1 ? -ym  : ym;
    vtx_next.pos_z  = nz   ? -zm  : zm;
    vtx_next.norm_x = nx   ? -xnm : xnm;
    vtx_next.norm_y = ncl1 ? -NRM_W'(cl1) : NRM_W'(cl1);
    vtx_next.norm_z = nz   ? -znm : znm;
    vtx_next.tex_u  = tu1;
    vtx_next.tex_v  = tv1;
    vtx_next.last   = last1;
    vtx_next.bad    = bad1;
    if (bad1) begin
      vtx_next.pos_x  = '0;
      vtx_next.pos_y  = '0;
      vtx_next.pos_z  = '0;
      vtx_next.norm_x = '0;
      vtx_next.norm_y = '0;
      vtx_next.norm_z = '0;
      vtx_next.tex_u  = '0;
      vtx_next.tex_v  = '0;
    end
  end

`ifndef SYNTH
  a_read_burst: assert property (@(posedge clk) disable iff (rst)
    rd_vld && rd_slot != 2'd3 |=> rd_vld) else $error("lookup burst broken");
  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    set_take |=> em_busy && em_k == 3'd0) else $error("emitter not restarted");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_vtx.bad |-> out_vtx.pos_x == '0 && out_vtx.norm_y == '0
      && out_vtx.tex_u == '0) else $error("bad tile carries data");
`endif

endmodule
